FILE: hw/rtl/qidpa_pkg.sv
// ----------------------------------------------------------------------------
// Queue id pool allocator package
// Request and result words, opcode, status and register codes.
// ----------------------------------------------------------------------------
package qidpa_pkg;

  localparam int OpW     = 2;
  localparam int ModeW   = 2;
  localparam int QIdxW   = 8;
  localparam int QidW    = 7;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2
  } opcode_e;

  typedef enum logic [ModeW-1:0] {
    MODE_ANY   = 2'd0,
    MODE_NAMED = 2'd1,
    MODE_BAD   = 2'd2
  } req_mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_IN_USE  = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUEUE_COUNT   = 1'd0,
    CFG_SPECIFIC_MODE = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ModeW-1:0] request_mode;
    logic [QIdxW-1:0] queue_index;
  } req_t;

  typedef struct packed {
    logic [QidW-1:0] queue_id;
    status_e         status;
    logic            used_flag;
  } res_t;

endpackage

FILE: hw/rtl/qidpa_ffs.sv
// ----------------------------------------------------------------------------
// Queue id pool first-free finder
// Priority encoder: index of the lowest set bit of the free vector.
// ----------------------------------------------------------------------------
module qidpa_ffs #(
  parameter int N = 128
) (
  input  logic [N-1:0]         free_i,
  output logic                 found_o,
  output logic [$clog2(N)-1:0] index_o
);

  localparam int IdxW = $clog2(N);

  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    // walk downwards so the lowest free id wins
    for (int i = N - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        found_o = 1'b1;
        index_o = IdxW'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/queue_id_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// Queue id pool allocator
// Used-bit bitmap serving allocate, free and test requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a word on req_i is taken at a rising edge with start
//   high and busy low. busy is held low, so a request may be issued every
//   cycle; one request per cycle is sustained.
//   Each request gives exactly one result word on result_o, shown for one
//   cycle with result_valid_o high. The word is latched into an input
//   register at acceptance and resolved against the bitmap in the next
//   cycle, so the strobe rises on the cycle after that.
//   Back-to-back requests see each other's bitmap updates.
//   The receiver cannot stall; results are never held or dropped.
//   Config channel: cfg_valid_i/cfg_ready_o, ready always high. Index 0 is
//   the queue count (clamped to MAX_QUEUES), index 1 the named-id enable.
//   Write only while no request is in flight.
//   Reset: every id is free, both registers are zero, no result pending.
// ----------------------------------------------------------------------------
module queue_id_pool_allocator_unit
  import qidpa_pkg::*;
#(
  parameter int MAX_QUEUES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                result_valid_o,
  output res_t                result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW = $clog2(MAX_QUEUES);
  localparam int CmpW = (IdxW > QIdxW) ? IdxW + 1 : QIdxW + 1;

  logic [CfgDataW-1:0]   queue_count_q;
  logic                  specific_mode_q;
  logic                  req_vld_q;
  req_t                  req_q;
  logic [MAX_QUEUES-1:0] used_q, used_d;
  logic                  res_vld_q;
  res_t                  res_q, res_d;

  logic [CmpW-1:0]       count;
  logic [CmpW-1:0]       idx_ext;
  logic [IdxW-1:0]       idx;
  logic                  in_range;
  logic [MAX_QUEUES-1:0] free_vec;
  logic                  scan_found;
  logic [IdxW-1:0]       scan_idx;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_count_q   <= '0;
      specific_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_QUEUE_COUNT:   queue_count_q   <= cfg_data_i;
        CFG_SPECIFIC_MODE: specific_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // active count clamped to the pool size
  always_comb begin
    count = (CmpW'(queue_count_q) > CmpW'(MAX_QUEUES)) ? CmpW'(MAX_QUEUES)
                                                        : CmpW'(queue_count_q);
    idx_ext  = CmpW'(req_q.queue_index);
    idx      = idx_ext[IdxW-1:0];
    in_range = idx_ext < count;
    for (int i = 0; i < MAX_QUEUES; i++) begin
      free_vec[i] = !used_q[i] && (CmpW'(i) < count);
    end
  end

  qidpa_ffs #(
    .N (MAX_QUEUES)
  ) u_ffs (
    .free_i  (free_vec),
    .found_o (scan_found),
    .index_o (scan_idx)
  );

  always_comb begin
    used_d          = used_q;
    res_d.queue_id  = '0;
    res_d.status    = ST_OK;
    res_d.used_flag = 1'b0;
    unique case (req_q.opcode)
      OP_ALLOC: begin
        if (specific_mode_q && (req_q.request_mode != MODE_ANY)) begin
          priority if (req_q.request_mode != MODE_NAMED) begin
            res_d.status = ST_INVALID;
          end else if (!in_range) begin
            res_d.status = ST_RANGE;
          end else if (used_q[idx]) begin
            res_d.status = ST_IN_USE;
          end else begin
            used_d[idx]    = 1'b1;
            res_d.queue_id = QidW'(req_q.queue_index);
          end
        end else if (scan_found) begin
          used_d[scan_idx] = 1'b1;
          res_d.queue_id   = QidW'(scan_idx);
        end else begin
          res_d.status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (in_range) begin
          used_d[idx] = 1'b0;
        end else begin
          res_d.status = ST_RANGE;
        end
      end
      OP_TEST: begin
        if (in_range) begin
          res_d.used_flag = used_q[idx];
        end else begin
          res_d.status = ST_RANGE;
        end
      end
      default: res_d.status = ST_INVALID;
    endcase
  end

  // bitmap and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= req_vld_q;
      if (req_vld_q) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Queue id pool allocator testbench
// Drives requests of all opcodes and config writes with random gaps, mirrors the
// used-bit bitmap in a local predictor and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
  import qidpa_pkg::*;

  localparam int MAX_IDS = 128;
  localparam logic [OpW-1:0]   OpSpare   = 2'd3;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  typedef struct {
    bit                  is_cfg;
    req_t                word;
    cfg_idx_e            reg_sel;
    logic [CfgDataW-1:0] value;
  } stim_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                req_start = 1'b0;
  logic                dut_busy;
  req_t                req_word = '0;
  logic                result_valid;
  res_t                result_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  bit [MAX_IDS-1:0]    used_map = '0;
  logic [CfgDataW-1:0] pool_count = '0;
  bit                  named_enable = 1'b0;

  stim_t pending_stim[$];
  res_t  expected_words[$];
  int    error_count = 0;
  logic  acc_req = 1'b0;
  logic  acc_cfg = 1'b0;
  int    quiet_cycles = 0;
  int    gap_left = 0;
  int    words_sent = 0;
  bit    calm_stretch = 1'b0;

  queue_id_pool_allocator_unit #(
    .MAX_QUEUES(MAX_IDS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (req_start),
    .busy           (dut_busy),
    .req_i          (req_word),
    .result_valid_o (result_valid),
    .result_o       (result_word),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic res_t predict_result(req_t w);
    res_t        r;
    int unsigned lim;
    int unsigned i;
    bit          found;
    r.queue_id  = '0;
    r.status    = ST_OK;
    r.used_flag = 1'b0;
    lim = (pool_count > MAX_IDS) ? MAX_IDS : pool_count;
    case (w.opcode)
      OP_ALLOC: begin
        if (named_enable && w.request_mode != MODE_ANY) begin
          if (w.request_mode != MODE_NAMED) r.status = ST_INVALID;
          else if (w.queue_index >= lim) r.status = ST_RANGE;
          else if (used_map[w.queue_index]) r.status = ST_IN_USE;
          else begin
            used_map[w.queue_index] = 1'b1;
            r.queue_id = w.queue_index[QidW-1:0];
          end
        end else begin
          // lowest free id below the active count
          r.status = ST_FULL;
          found = 1'b0;
          for (i = 0; i < lim; i++) begin
            if (!found && !used_map[i]) begin
              used_map[i] = 1'b1;
              r.queue_id = i[QidW-1:0];
              r.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      OP_FREE: begin
        if (w.queue_index >= lim) r.status = ST_RANGE;
        else used_map[w.queue_index] = 1'b0;
      end
      OP_TEST: begin
        if (w.queue_index >= lim) r.status = ST_RANGE;
        else r.used_flag = used_map[w.queue_index];
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic add_req(logic [OpW-1:0] op, logic [ModeW-1:0] mode, logic [QIdxW-1:0] idx);
    stim_t s;
    s.is_cfg = 1'b0;
    s.word.opcode = op;
    s.word.request_mode = mode;
    s.word.queue_index = idx;
    s.reg_sel = CFG_QUEUE_COUNT;
    s.value = '0;
    pending_stim.push_back(s);
  endtask

  task automatic add_cfg(cfg_idx_e sel, logic [CfgDataW-1:0] v);
    stim_t s;
    s.is_cfg = 1'b1;
    s.word = '0;
    s.reg_sel = sel;
    s.value = v;
    pending_stim.push_back(s);
  endtask

  // monitor: result check first, then record this edge's handshakes
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (result_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", result_word);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_word.queue_id !== want.queue_id) begin
            $error("queue_id: expected %0d, got %0d", want.queue_id, result_word.queue_id);
            error_count++;
          end
          if (result_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_word.status);
            error_count++;
          end
          if (result_word.used_flag !== want.used_flag) begin
            $error("used_flag: expected %0d, got %0d", want.used_flag, result_word.used_flag);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_QUEUE_COUNT) pool_count = cfg_data;
        else named_enable = cfg_data[0];
      end
      if (req_start && !dut_busy) expected_words.push_back(predict_result(req_word));
    end
    acc_req <= rst_ni && req_start && !dut_busy;
    acc_cfg <= rst_ni && cfg_valid && cfg_ready;
    quiet_cycles <= (rst_ni && req_start && !dut_busy) ? 0 : quiet_cycles + 1;
  end

  // driver: one word on the bus at a time, changed only at the falling edge
  always @(negedge clk_i) begin
    logic  nxt_start;
    logic  nxt_cfg;
    stim_t head;
    nxt_start = req_start;
    nxt_cfg   = cfg_valid;
    if (!rst_ni) begin
      nxt_start = 1'b0;
      nxt_cfg   = 1'b0;
    end else if (!(req_start && !acc_req) && !(cfg_valid && !acc_cfg)) begin
      nxt_start = 1'b0;
      nxt_cfg   = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_stim.size() > 0) begin
        head = pending_stim[0];
        if (head.is_cfg) begin
          // register writes only once the pipe has drained
          if (expected_words.size() == 0 && quiet_cycles >= 4) begin
            void'(pending_stim.pop_front());
            cfg_index <= head.reg_sel;
            cfg_data  <= head.value;
            nxt_cfg = 1'b1;
          end
        end else begin
          void'(pending_stim.pop_front());
          req_word <= head.word;
          nxt_start = 1'b1;
          words_sent++;
          if (words_sent % 40 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
          gap_left = pick_gap();
        end
      end
    end
    req_start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  initial begin
    int unsigned         ph;
    int unsigned         n;
    int unsigned         k;
    int unsigned         lim;
    int unsigned         alloc_bias;
    int unsigned         n_items;
    logic [CfgDataW-1:0] cnt;
    logic                mode_bit;
    logic [6:0]          pad;
    logic [OpW-1:0]      op;
    logic [ModeW-1:0]    md;
    logic [QIdxW-1:0]    idx;

    // registers at reset: empty pool
    add_req(OP_ALLOC, MODE_ANY, 8'd0);
    add_req(OP_FREE, MODE_ANY, 8'd0);
    add_req(OP_TEST, MODE_ANY, 8'd0);
    add_req(OpSpare, MODE_ANY, 8'd0);
    // count above the pool saturates; named ids ignored with the mode off
    add_cfg(CFG_QUEUE_COUNT, 8'd255);
    add_cfg(CFG_SPECIFIC_MODE, 8'hfe);
    add_req(OP_ALLOC, MODE_NAMED, 8'd100);
    add_req(OP_ALLOC, MODE_BAD, 8'd255);
    add_req(OP_TEST, MODE_ANY, 8'd1);
    add_req(OP_TEST, MODE_ANY, 8'd127);
    add_req(OP_TEST, MODE_ANY, 8'd128);
    add_req(OP_FREE, MODE_ANY, 8'd255);
    add_req(OP_FREE, MODE_ANY, 8'd1);
    add_req(OP_TEST, MODE_ANY, 8'd1);
    // named claims on a tiny pool
    add_cfg(CFG_QUEUE_COUNT, 8'd3);
    add_cfg(CFG_SPECIFIC_MODE, 8'h01);
    add_req(OP_ALLOC, MODE_NAMED, 8'd2);
    add_req(OP_ALLOC, MODE_NAMED, 8'd2);
    add_req(OP_ALLOC, MODE_NAMED, 8'd3);
    add_req(OP_ALLOC, MODE_BAD, 8'd1);
    add_req(OP_ALLOC, ModeSpare, 8'd1);
    add_req(OP_ALLOC, MODE_ANY, 8'd0);
    add_req(OP_ALLOC, MODE_ANY, 8'd0);
    add_req(OpSpare, ModeSpare, 8'd255);

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cnt = 8'd1;
        1: cnt = 8'd128;
        2: cnt = 8'd255;
        3: cnt = 8'd0;
        4: cnt = 8'd129;
        5: cnt = 8'd2;
        6: cnt = 8'($urandom_range(0, 255));
        default: cnt = 8'($urandom_range(1, 12));
      endcase
      mode_bit = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      pad = 7'($urandom);
      add_cfg(CFG_QUEUE_COUNT, cnt);
      add_cfg(CFG_SPECIFIC_MODE, {pad, mode_bit});
      lim = (cnt > MAX_IDS) ? MAX_IDS : cnt;
      alloc_bias = (ph == 1) ? 80 : $urandom_range(30, 70);
      n_items = (ph == 1) ? 160 : 40;
      for (n = 0; n < n_items; n++) begin
        if ($urandom_range(0, 99) < alloc_bias) op = OP_ALLOC;
        else if ($urandom_range(0, 19) == 0) op = OpSpare;
        else op = $urandom_range(0, 1) ? OP_FREE : OP_TEST;
        k = $urandom_range(0, 9);
        md = (k < 5) ? MODE_ANY : (k < 8) ? MODE_NAMED : (k == 8) ? MODE_BAD : ModeSpare;
        if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(0, 255));
        else idx = 8'($urandom_range(0, lim + 1));
        add_req(op, md, idx);
      end
    end

    while (!rst_ni) @(posedge clk_i);
    while (pending_stim.size() > 0 || req_start || cfg_valid || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #1000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
